// ----- design/hqp_pkg.sv -----
// Package for the quadratic-probe hash table: sizes, codes and state encoding.
// No dependencies; used by hqp_hash and the top module.
`timescale 1ns / 1ps

package hqp_pkg;

  // Table geometry
  localparam int TABLE_SIZE = 8;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
  // floor(log2(TABLE_SIZE)), the number of hash bits kept
  localparam int SIZE_LOG2  = ((1 << IDX_W) == TABLE_SIZE) ? IDX_W : IDX_W - 1;

  // Knuth multiplicative hash constant
  localparam logic [31:0] KNUTH_MULT = 32'd2654435769;

  // Entry word stored in the slot memory: key over value
  localparam int ENTRY_W = 64;

  // Action codes
  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_FOUND     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_HASH  = 3'b010,
    S_PROBE = 3'b100
  } state_t;

endpackage

// ----- design/hqp_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module hqp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/hqp_hash.sv -----
// Home-slot hash: Knuth multiplicative hash, top bits of the 32-bit product.
// Depends on hqp_pkg.
`timescale 1ns / 1ps

module hqp_hash (
  input  logic signed [31:0]             key,
  output logic [hqp_pkg::IDX_W-1:0]      home
);

  logic [31:0] key_u;
  logic [31:0] prod;

  // low 32 bits of the product, same for signed and unsigned keys
  assign key_u = $unsigned(key);
  assign prod  = hqp_pkg::KNUTH_MULT * key_u;

  // keep the top floor(log2 size) bits; always below the table size
  assign home = hqp_pkg::IDX_W'(prod >> (32 - hqp_pkg::SIZE_LOG2));

endmodule

// ----- design/hash_table_quadratic_probe_top.sv -----
// Hash table with triangular probing. S_HASH loads the home slot, then S_PROBE
// walks the probes: an insert ends at the first free slot, a lookup on a hit,
// either after TABLE_SIZE probes at most; a new command is taken once busy falls.
// The probe loop visits one slot per cycle; lookups read it via the slot RAM read port.
// Result strobe lasts one cycle and cannot be stalled. Synchronous reset clears
// the sequencer and every slot's used bit, leaving the table empty.
// Depends on hqp_pkg, hqp_hash, hqp_ram.
`timescale 1ns / 1ps

module hash_table_quadratic_probe_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_action,
  input  logic signed [31:0] in_key,
  input  logic [31:0]        in_entry_value,
  output logic               out_strobe,
  output logic [1:0]         out_status,
  output logic [31:0]        out_found_value
);

  localparam int IDX_W = hqp_pkg::IDX_W;
  localparam int CNT_W = hqp_pkg::CNT_W;

  hqp_pkg::state_t state_r;

  // captured command
  logic               action_r;
  logic signed [31:0] key_r;
  logic [31:0]        value_r;

  // probe sequencer
  logic [IDX_W-1:0] slot_r;
  logic [CNT_W-1:0] probe_r;
  logic             chk_vld_r;
  logic             chk_last_r;
  logic [IDX_W-1:0] chk_slot_r;
  logic [hqp_pkg::TABLE_SIZE-1:0] used_r;

  // result register
  logic        out_strobe_r;
  logic [1:0]  status_r;
  logic [31:0] found_r;

  logic [IDX_W-1:0] home;
  logic [IDX_W:0]   slot_sum;
  logic [IDX_W-1:0] slot_nxt;
  logic             issue;
  logic             last_probe;
  logic             ram_we;
  logic [hqp_pkg::ENTRY_W-1:0] ram_rdata;
  logic [31:0]      rd_key;
  logic [31:0]      rd_value;
  logic             hit;

  hqp_hash u_hash (
    .key  (key_r),
    .home (home)
  );

  hqp_ram #(
    .WIDTH (hqp_pkg::ENTRY_W),
    .DEPTH (hqp_pkg::TABLE_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata ({$unsigned(key_r), value_r}),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  assign rd_key   = ram_rdata[63:32];
  assign rd_value = ram_rdata[31:0];

  // next slot: add the next triangular step, fold once mod size
  assign slot_sum = {1'b0, slot_r} + {1'b0, IDX_W'(probe_r + CNT_W'(1))};
  assign slot_nxt = (slot_sum >= (IDX_W+1)'(hqp_pkg::TABLE_SIZE))
                  ? IDX_W'(slot_sum - (IDX_W+1)'(hqp_pkg::TABLE_SIZE))
                  : IDX_W'(slot_sum);

  assign issue      = (probe_r != CNT_W'(hqp_pkg::TABLE_SIZE));
  assign last_probe = (probe_r == CNT_W'(hqp_pkg::TABLE_SIZE - 1));

  // lookup hit on the slot read last cycle
  assign hit = chk_vld_r && used_r[chk_slot_r] && (rd_key == $unsigned(key_r));

  assign ram_we = (state_r == hqp_pkg::S_PROBE) && (action_r == hqp_pkg::ACT_INSERT)
                && !used_r[slot_r];

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= hqp_pkg::S_IDLE;
      used_r       <= '0;
      chk_vld_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        hqp_pkg::S_IDLE: begin
          if (start) begin
            action_r <= in_action;
            key_r    <= in_key;
            value_r  <= in_entry_value;
            state_r  <= hqp_pkg::S_HASH;
          end
        end
        hqp_pkg::S_HASH: begin
          slot_r    <= home;
          probe_r   <= '0;
          chk_vld_r <= 1'b0;
          state_r   <= hqp_pkg::S_PROBE;
        end
        hqp_pkg::S_PROBE: begin
          if (action_r == hqp_pkg::ACT_INSERT) begin
            // insert: used bits are in flops, decide in the same cycle
            if (!used_r[slot_r]) begin
              used_r[slot_r] <= 1'b1;
              status_r       <= hqp_pkg::ST_INSERTED;
              found_r        <= '0;
              out_strobe_r   <= 1'b1;
              state_r        <= hqp_pkg::S_IDLE;
            end else if (last_probe) begin
              status_r     <= hqp_pkg::ST_FULL;
              found_r      <= '0;
              out_strobe_r <= 1'b1;
              state_r      <= hqp_pkg::S_IDLE;
            end else begin
              slot_r  <= slot_nxt;
              probe_r <= probe_r + CNT_W'(1);
            end
          end else begin
            // lookup: read one slot per cycle, check it the cycle after
            if (hit) begin
              status_r     <= hqp_pkg::ST_FOUND;
              found_r      <= rd_value;
              out_strobe_r <= 1'b1;
              chk_vld_r    <= 1'b0;
              state_r      <= hqp_pkg::S_IDLE;
            end else if (chk_vld_r && chk_last_r) begin
              status_r     <= hqp_pkg::ST_NOT_FOUND;
              found_r      <= '0;
              out_strobe_r <= 1'b1;
              chk_vld_r    <= 1'b0;
              state_r      <= hqp_pkg::S_IDLE;
            end else begin
              chk_vld_r  <= issue;
              chk_last_r <= last_probe;
              chk_slot_r <= slot_r;
              if (issue) begin
                slot_r  <= slot_nxt;
                probe_r <= probe_r + CNT_W'(1);
              end
            end
          end
        end
        default: begin
          state_r <= hqp_pkg::S_IDLE;
        end
      endcase
    end
  end

  assign busy            = (state_r != hqp_pkg::S_IDLE);
  assign out_strobe      = out_strobe_r;
  assign out_status      = status_r;
  assign out_found_value = found_r;

endmodule
